### rtl/lpfr_pkg.sv
package lpfr_pkg;

  localparam logic [15:0] MARKER_WORD     = 16'hDEAD;
  localparam logic [15:0] FRAME_LIMIT_RST = 16'd4096;
  localparam logic [15:0] HDR_SHORT       = 16'd2;
  localparam logic [15:0] HDR_LONG        = 16'd4;

  localparam logic [1:0] TAG_HEADER = 2'd0;
  localparam logic [1:0] TAG_BODY   = 2'd1;
  localparam logic [1:0] TAG_LAST   = 2'd2;
  localparam logic [1:0] TAG_ERROR  = 2'd3;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } rx_phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [1:0]  byte_phase;
    logic        marker_seen;
    logic [15:0] frame_length;
  } rx_result_t;

endpackage

### rtl/length_prefixed_frame_receiver_unit.sv
// An accepted byte is registered into the queue and offered on the output once the entries ahead of it are taken.
// Throughput: one byte per cycle while the queue is not full; the parser is combinational
// and a two-entry queue lets the output stall without stopping input at once.
// Reset (rst, synchronous): parser back to header start, queue empty,
// frame_limit back to 4096.
module length_prefixed_frame_receiver_unit import lpfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_offset,
  output logic [1:0]  byte_phase,
  output logic        marker_seen,
  output logic [15:0] frame_length
);

  rx_result_t result;
  rx_result_t head;
  logic       full;
  logic       take;
  logic       pop;

  assign in_stall = full;
  assign take     = in_valid && !full;
  assign pop      = out_valid && !out_stall;

  lpfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx_byte),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

  lpfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (result),
    .pop       (pop),
    .full      (full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign data_byte    = head.data_byte;
  assign byte_offset  = head.byte_offset;
  assign byte_phase   = head.byte_phase;
  assign marker_seen  = head.marker_seen;
  assign frame_length = head.frame_length;

endmodule

### rtl/lpfr_front.sv
module lpfr_front import lpfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       cfg_we,
  input  logic [15:0] cfg_data,
  output rx_result_t result
);

  logic [15:0] frame_limit;
  rx_phase_t   rx_phase, rx_phase_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  header_lo, header_lo_next;
  logic [15:0] length_held, length_held_next;
  logic        marker_flag, marker_flag_next;

  rx_phase_t   e_phase;
  logic [15:0] e_seen;
  logic [7:0]  e_hlo;
  logic [15:0] e_len;
  logic        e_mark;
  logic        stale;
  logic        do_finish;
  logic        fin_long;
  logic [15:0] fin_len;
  logic [15:0] hsize;
  logic [15:0] word;
  logic [16:0] seen_inc;
  logic        restart;
  logic [1:0]  tag;
  logic [15:0] len_out;
  logic        mark_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= FRAME_LIMIT_RST;
    end else if (cfg_we) begin
      frame_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase    <= PH_HEADER;
      bytes_seen  <= '0;
      header_lo   <= '0;
      length_held <= '0;
      marker_flag <= 1'b0;
    end else if (take) begin
      rx_phase    <= rx_phase_next;
      bytes_seen  <= bytes_seen_next;
      header_lo   <= header_lo_next;
      length_held <= length_held_next;
      marker_flag <= marker_flag_next;
    end
  end

  always_comb begin
    // drop a frame whose count has run past its header or its length
    stale = ((rx_phase == PH_BODY) && (bytes_seen >= length_held)) ||
            ((rx_phase == PH_HEADER) && (bytes_seen > 16'd3));
    e_phase = stale ? PH_HEADER : rx_phase;
    e_seen  = stale ? 16'd0 : bytes_seen;
    e_hlo   = stale ? 8'd0 : header_lo;
    e_len   = stale ? 16'd0 : length_held;
    e_mark  = stale ? 1'b0 : marker_flag;

    rx_phase_next    = e_phase;
    bytes_seen_next  = e_seen;
    header_lo_next   = e_hlo;
    length_held_next = e_len;
    marker_flag_next = e_mark;

    tag       = TAG_HEADER;
    len_out   = '0;
    mark_out  = e_mark;
    restart   = 1'b0;
    do_finish = 1'b0;
    fin_long  = 1'b0;
    fin_len   = '0;
    word      = {rx_byte, e_hlo};
    seen_inc  = {1'b0, e_seen} + 17'd1;

    if (e_phase == PH_BODY) begin
      len_out = e_len;
      if (seen_inc == {1'b0, e_len}) begin
        tag     = TAG_LAST;
        restart = 1'b1;
      end else begin
        tag             = TAG_BODY;
        bytes_seen_next = seen_inc[15:0];
      end
    end else begin
      case (e_seen[1:0])
        2'd0: begin
          header_lo_next  = rx_byte;
          bytes_seen_next = 16'd1;
        end
        2'd1: begin
          if (word == MARKER_WORD) begin
            marker_flag_next = 1'b1;
            mark_out         = 1'b1;
            bytes_seen_next  = 16'd2;
          end else begin
            len_out   = word;
            do_finish = 1'b1;
            fin_len   = word;
          end
        end
        2'd2: begin
          length_held_next = {8'd0, rx_byte};
          bytes_seen_next  = 16'd3;
        end
        default: begin
          len_out   = {rx_byte, e_len[7:0]};
          do_finish = 1'b1;
          fin_long  = 1'b1;
          fin_len   = {rx_byte, e_len[7:0]};
        end
      endcase
    end

    hsize = fin_long ? HDR_LONG : HDR_SHORT;
    if (do_finish) begin
      if ((fin_len < hsize) || (fin_len >= frame_limit)) begin
        tag     = TAG_ERROR;
        restart = 1'b1;
      end else if (fin_len == hsize) begin
        tag     = TAG_LAST;
        restart = 1'b1;
      end else begin
        rx_phase_next    = PH_BODY;
        bytes_seen_next  = hsize;
        length_held_next = fin_len;
      end
    end

    if (restart) begin
      rx_phase_next    = PH_HEADER;
      bytes_seen_next  = '0;
      header_lo_next   = '0;
      length_held_next = '0;
      marker_flag_next = 1'b0;
    end

    result.data_byte    = rx_byte;
    result.byte_offset  = e_seen;
    result.byte_phase   = tag;
    result.marker_seen  = mark_out;
    result.frame_length = len_out;
  end

endmodule

### rtl/lpfr_queue.sv
module lpfr_queue import lpfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rx_result_t push_data,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output rx_result_t head
);

  rx_result_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

endmodule

### sim/length_prefixed_frame_receiver_unit_tb.sv
module length_prefixed_frame_receiver_unit_tb import lpfr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [7:0] MARK_LO = MARKER_WORD[7:0];
  localparam logic [7:0] MARK_HI = MARKER_WORD[15:8];

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_byte;
  logic [15:0] byte_offset;
  logic [1:0]  byte_phase;
  logic        marker_seen;
  logic [15:0] frame_length;

  // receiver copy of the deframer state
  logic [15:0] lim = FRAME_LIMIT_RST;
  rx_phase_t   cur_phase = PH_HEADER;
  logic [15:0] cur_count = '0;
  logic [15:0] cur_word = '0;
  logic [15:0] cur_len = '0;
  logic        cur_marker = 1'b0;

  logic [7:0]  byte_q[$];
  rx_result_t  want_tags[$];
  int unsigned n_pushed = 0;
  int unsigned n_checked = 0;
  int unsigned n_bad = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_max = 0;
  bit          hold_arm = 1'b0;

  length_prefixed_frame_receiver_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_offset  (byte_offset),
    .byte_phase   (byte_phase),
    .marker_seen  (marker_seen),
    .frame_length (frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void restart_frame();
    cur_phase  = PH_HEADER;
    cur_count  = '0;
    cur_word   = '0;
    cur_len    = '0;
    cur_marker = 1'b0;
  endfunction

  function automatic logic [1:0] close_header(input logic [15:0] len,
                                              input logic [15:0] hsize);
    cur_len = len;
    if (len < hsize || len >= lim) begin
      restart_frame();
      return TAG_ERROR;
    end
    if (len == hsize) begin
      restart_frame();
      return TAG_LAST;
    end
    cur_phase = PH_BODY;
    cur_count = hsize;
    return TAG_HEADER;
  endfunction

  function automatic rx_result_t tag_rx_byte(input logic [7:0] b);
    rx_result_t r;
    logic [15:0] len;
    r.data_byte    = b;
    r.byte_phase   = TAG_HEADER;
    r.frame_length = '0;
    if (cur_phase == PH_BODY && cur_count >= cur_len)
      restart_frame();
    if (cur_phase == PH_HEADER && cur_count > 16'd3)
      restart_frame();
    r.byte_offset = cur_count;
    r.marker_seen = cur_marker;
    if (cur_phase == PH_BODY) begin
      r.frame_length = cur_len;
      if ({1'b0, cur_count} + 17'd1 == {1'b0, cur_len}) begin
        r.byte_phase = TAG_LAST;
        restart_frame();
      end else begin
        r.byte_phase = TAG_BODY;
        cur_count = cur_count + 16'd1;
      end
    end else begin
      case (cur_count)
        16'd0: begin
          cur_word  = {8'h00, b};
          cur_count = 16'd1;
        end
        16'd1: begin
          cur_word = {b, cur_word[7:0]};
          if (cur_word == MARKER_WORD) begin
            cur_marker    = 1'b1;
            r.marker_seen = 1'b1;
            cur_count     = 16'd2;
          end else begin
            r.frame_length = cur_word;
            r.byte_phase   = close_header(cur_word, HDR_SHORT);
          end
        end
        16'd2: begin
          cur_len   = {8'h00, b};
          cur_count = 16'd3;
        end
        default: begin
          len            = {b, cur_len[7:0]};
          r.frame_length = len;
          r.byte_phase   = close_header(len, HDR_LONG);
        end
      endcase
    end
    return r;
  endfunction

  // sender: bursts of random length, random gaps between them
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        want_tags.push_back(tag_rx_byte(rx_byte));
      // hold a stalled request as it is
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid <= 1'b1;
          rx_byte  <= byte_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (gap_max == 0 || $urandom_range(0, 3) == 0) ?
                         0 : $urandom_range(1, gap_max);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern from a randomly redrawn mode (none, light, heavy, toggle), plus one long hold-off
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 64 == 0)
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall <= stall_tick[0];
        endcase
      end
    end
  end

  task automatic flag_bad(input string what, input rx_result_t e, input rx_result_t g);
    if (n_bad < 10)
      $display({"%0t: %s: expected byte %02h off %0d phase %0d mark %0d len %0d,",
                " got byte %02h off %0d phase %0d mark %0d len %0d"},
               $realtime, what, e.data_byte, e.byte_offset, e.byte_phase, e.marker_seen,
               e.frame_length, g.data_byte, g.byte_offset, g.byte_phase, g.marker_seen,
               g.frame_length);
    n_bad++;
  endtask

  always @(posedge clk) begin
    rx_result_t got;
    rx_result_t exp_tag;
    if (!rst && out_valid && !out_stall) begin
      got.data_byte    = data_byte;
      got.byte_offset  = byte_offset;
      got.byte_phase   = byte_phase;
      got.marker_seen  = marker_seen;
      got.frame_length = frame_length;
      if (want_tags.size() == 0) begin
        flag_bad("result with no request pending", '0, got);
      end else begin
        exp_tag = want_tags.pop_front();
        n_checked++;
        if (got.data_byte !== exp_tag.data_byte || got.byte_offset !== exp_tag.byte_offset ||
            got.byte_phase !== exp_tag.byte_phase || got.marker_seen !== exp_tag.marker_seen ||
            got.frame_length !== exp_tag.frame_length)
          flag_bad("mismatch", exp_tag, got);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    n_pushed++;
  endtask

  task automatic push_frame(input bit marker, input int unsigned len);
    int unsigned hs;
    int unsigned body;
    hs = marker ? 4 : 2;
    if (marker) begin
      push_byte(MARK_LO);
      push_byte(MARK_HI);
    end
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    body = (len > hs && len < lim) ? len - hs : 0;
    repeat (body) push_byte($urandom_range(0, 255));
  endtask

  // mostly well-formed frames with random content, some noise and bad lengths
  task automatic push_random(input int unsigned n);
    int unsigned start;
    int unsigned hs;
    int unsigned hi;
    int unsigned len;
    int unsigned s;
    bit          marker;
    start = n_pushed;
    while (n_pushed - start < n) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 6)) push_byte($urandom_range(0, 255));
      end else begin
        marker = $urandom_range(0, 1);
        hs     = marker ? 4 : 2;
        s      = $urandom_range(0, 99);
        if (s < 10) begin
          len = $urandom_range(0, hs - 1);
        end else if (s < 18) begin
          len = $urandom_range(lim, 65535);
        end else if (s < 25) begin
          len = hs;
        end else begin
          hi = hs + ((s < 90) ? 10 : 60);
          if (lim != 0 && hi > lim - 1)
            hi = lim - 1;
          len = (hi < hs) ? hs : $urandom_range(hs, hi);
        end
        push_frame(marker, len);
      end
    end
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    lim = v;
  endtask

  // wait until every pushed byte has come back, then let the pipe settle
  task automatic drain();
    while (n_checked != n_pushed) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset limit
    gap_max = 6;
    push_frame(0, 2);       // frame ends on its header
    push_frame(0, 3);
    push_frame(0, 1);       // shorter than header
    push_frame(0, 0);
    push_frame(1, 4);       // marker frame ends on its header
    push_frame(1, 3);       // marker frame shorter than header
    push_frame(1, 5);
    push_frame(0, 65535);   // over the limit
    push_frame(1, 65535);
    drain();

    write_limit(16'd5);
    push_random(80);
    drain();

    write_limit(16'hFFFF);
    push_frame(1, 100);
    push_random(100);
    drain();

    // a zero limit rejects everything
    gap_max = 3;
    write_limit(16'd0);
    push_frame(0, 2);
    push_frame(1, 4);
    repeat (6) push_byte($urandom_range(0, 255));
    drain();

    // full-rate sender against a long receiver hold-off
    gap_max = 0;
    write_limit(16'd64);
    hold_arm = 1'b1;
    push_frame(0, 63);
    push_frame(1, 64);
    push_random(100);
    drain();

    gap_max = 8;
    write_limit(FRAME_LIMIT_RST);
    push_random(60);
    drain();

    repeat (10) @(posedge clk);
    if (n_bad == 0 && want_tags.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/lpfr_pkg.sv
rtl/lpfr_front.sv
rtl/lpfr_queue.sv
rtl/length_prefixed_frame_receiver_unit.sv
sim/length_prefixed_frame_receiver_unit_tb.sv
